[hw/rtl/dcrb_pkg.sv]
// Package for the display controller register block.
// Holds the beat types, item kind codes, special word addresses and bit masks.
// No dependencies.
package dcrb_pkg;

    // Field widths fixed by the bus format
    localparam int unsigned KIND_W = 2;
    localparam int unsigned IDX_W  = 10;
    localparam int unsigned DATA_W = 32;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

    // Word addresses (byte offset / 4)
    localparam logic [IDX_W-1:0] W_CTRL  = 10'd0;
    localparam logic [IDX_W-1:0] W_SET   = 10'd1;
    localparam logic [IDX_W-1:0] W_CLR   = 10'd2;
    localparam logic [IDX_W-1:0] W_TOG   = 10'd3;
    localparam logic [IDX_W-1:0] W_DISP  = 10'd4;   // byte 0x10
    localparam logic [IDX_W-1:0] W_STAT0 = 10'd9;   // byte 0x24
    localparam logic [IDX_W-1:0] W_ENA0  = 10'd10;  // byte 0x28
    localparam logic [IDX_W-1:0] W_STAT1 = 10'd12;  // byte 0x30
    localparam logic [IDX_W-1:0] W_ENA1  = 10'd13;  // byte 0x34
    localparam logic [IDX_W-1:0] W_LAYER = 10'd133; // byte 0x214

    // Bit masks
    localparam logic [DATA_W-1:0] BIT_SWRST   = 32'h8000_0000;
    localparam logic [DATA_W-1:0] BIT_DISPON  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] BIT_LAYEREN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] BIT_SHADOW  = 32'h4000_0000;
    localparam logic [DATA_W-1:0] BIT_VSYNC   = 32'h0000_0001;
    localparam logic [DATA_W-1:0] BIT_VSBLANK = 32'h0000_0004;

    // Input beat
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  word_index;
        logic [DATA_W-1:0] write_data;
    } t_in_item;

    // Result beat
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_line;
        logic              display_enabled;
    } t_out_item;

    // Status from the control-register bank toward the top level
    typedef struct packed {
        logic              hit;      // index is a flop-backed word or an alias
        logic [DATA_W-1:0] rd_val;   // read value for a hit
        logic              irq;      // interrupt after this beat
        logic              disp_en;  // layer on after this beat
    } t_ctrl_status;

endpackage

[hw/rtl/dcrb_ctrl_regs.sv]
// Flop-backed special words of the register block: control and its aliases,
// display, interrupt status/enable pairs and layer control.
// Depends on dcrb_pkg.
module dcrb_ctrl_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  dcrb_pkg::t_in_item  i_item,
    output dcrb_pkg::t_ctrl_status o_status
);

    logic [dcrb_pkg::DATA_W-1:0] r_ctrl, r_disp, r_stat0, r_ena0, r_stat1, r_ena1, r_layer;
    logic [dcrb_pkg::DATA_W-1:0] n_ctrl, n_disp, n_stat0, n_ena0, n_stat1, n_ena1, n_layer;
    logic [dcrb_pkg::DATA_W-1:0] v;
    logic                        is_wr, is_rd, is_tick, layer_on;
    logic [dcrb_pkg::IDX_W-1:0]  idx;

    assign idx     = i_item.word_index;
    assign v       = i_item.write_data;
    assign is_rd   = i_vld && (i_item.kind == dcrb_pkg::KIND_READ);
    assign is_wr   = i_vld && (i_item.kind == dcrb_pkg::KIND_WRITE);
    assign is_tick = i_vld && (i_item.kind == dcrb_pkg::KIND_TICK);
    assign layer_on = ((r_layer & dcrb_pkg::BIT_LAYEREN) != '0) &&
                      ((r_disp & dcrb_pkg::BIT_DISPON) != '0);

    // Next values of the special words
    always_comb begin
        n_ctrl  = r_ctrl;
        n_disp  = r_disp;
        n_stat0 = r_stat0;
        n_ena0  = r_ena0;
        n_stat1 = r_stat1;
        n_ena1  = r_ena1;
        n_layer = r_layer;
        if (is_wr) begin
            case (idx)
                dcrb_pkg::W_CTRL:  n_ctrl  = v & ~dcrb_pkg::BIT_SWRST;
                dcrb_pkg::W_SET:   n_ctrl  = (r_ctrl | v) & ~dcrb_pkg::BIT_SWRST;
                dcrb_pkg::W_CLR:   n_ctrl  = (r_ctrl & ~v) & ~dcrb_pkg::BIT_SWRST;
                dcrb_pkg::W_TOG:   n_ctrl  = (r_ctrl ^ v) & ~dcrb_pkg::BIT_SWRST;
                dcrb_pkg::W_DISP:  n_disp  = v;
                dcrb_pkg::W_STAT0: n_stat0 = r_stat0 & ~v;
                dcrb_pkg::W_ENA0:  n_ena0  = v;
                dcrb_pkg::W_STAT1: n_stat1 = r_stat1 & ~v;
                dcrb_pkg::W_ENA1:  n_ena1  = v;
                dcrb_pkg::W_LAYER: n_layer = v & ~dcrb_pkg::BIT_SHADOW;
                default: ;
            endcase
        end else if (is_tick && layer_on) begin
            n_stat0 = r_stat0 | dcrb_pkg::BIT_VSYNC | dcrb_pkg::BIT_VSBLANK;
        end
    end

    // Read mux, hit decode, and interrupt and layer status after this beat
    always_comb begin
        o_status.hit    = 1'b1;
        o_status.rd_val = '0;
        case (idx)
            dcrb_pkg::W_CTRL,
            dcrb_pkg::W_SET,
            dcrb_pkg::W_CLR,
            dcrb_pkg::W_TOG:   o_status.rd_val = r_ctrl;
            dcrb_pkg::W_DISP:  o_status.rd_val = r_disp;
            dcrb_pkg::W_STAT0: o_status.rd_val = r_stat0;
            dcrb_pkg::W_ENA0:  o_status.rd_val = r_ena0;
            dcrb_pkg::W_STAT1: o_status.rd_val = r_stat1;
            dcrb_pkg::W_ENA1:  o_status.rd_val = r_ena1;
            dcrb_pkg::W_LAYER: o_status.rd_val = r_layer;
            default:           o_status.hit    = 1'b0;
        endcase
        if (!is_rd) begin
            o_status.rd_val = '0;
        end
        o_status.irq     = ((n_stat0 & n_ena0) | (n_stat1 & n_ena1)) != '0;
        o_status.disp_en = ((n_layer & dcrb_pkg::BIT_LAYEREN) != '0) &&
                           ((n_disp & dcrb_pkg::BIT_DISPON) != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl  <= '0;
            r_disp  <= '0;
            r_stat0 <= '0;
            r_ena0  <= '0;
            r_stat1 <= '0;
            r_ena1  <= '0;
            r_layer <= '0;
        end else begin
            r_ctrl  <= n_ctrl;
            r_disp  <= n_disp;
            r_stat0 <= n_stat0;
            r_ena0  <= n_ena0;
            r_stat1 <= n_stat1;
            r_ena1  <= n_ena1;
            r_layer <= n_layer;
        end
    end

endmodule

[hw/rtl/dcrb_word_mem.sv]
// Plain read/write storage words of the register block, one memory with a
// registered read port, write-to-read bypass and a clearing pass after reset.
// Depends on dcrb_pkg.
module dcrb_word_mem #(
    parameter int unsigned NUM_REGS = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [$clog2(NUM_REGS)-1:0]   i_rd_idx,
    input  logic                          i_wr_en,
    input  logic [$clog2(NUM_REGS)-1:0]   i_wr_idx,
    input  logic [dcrb_pkg::DATA_W-1:0]   i_wr_data,
    output logic [dcrb_pkg::DATA_W-1:0]   o_rd_data,
    output logic                          o_clearing
);

    localparam int unsigned AW = $clog2(NUM_REGS);
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_REGS - 1);

    logic [dcrb_pkg::DATA_W-1:0] r_mem [NUM_REGS];
    logic [dcrb_pkg::DATA_W-1:0] r_rd_data;
    logic                        r_clearing;
    logic [AW-1:0]               r_clr_idx;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [dcrb_pkg::DATA_W-1:0] mem_wdata;

    // Write port: zero sweep after reset, else the bus write
    assign mem_we    = r_clearing || i_wr_en;
    assign mem_waddr = r_clearing ? r_clr_idx : i_wr_idx;
    assign mem_wdata = r_clearing ? '0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    // Registered read, forwarding a same-cycle write to the same word
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_idx == i_rd_idx)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_idx];
            end
        end
    end

    // Clearing pass sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            if (r_clr_idx == LAST_IDX) begin
                r_clearing <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

[hw/rtl/display_controller_register_block_unit.sv]
// Top level of the display controller register block.
// Depends on dcrb_pkg, dcrb_ctrl_regs and dcrb_word_mem.
//
// Usage:
//   Input channel: drive i_item and raise i_start; the beat is taken at a
//   rising edge where i_start is high and o_busy is low. A beat is a bus
//   read, a bus write or a vblank tick.
//   Result channel: every taken beat gives exactly one result on o_result,
//   marked by o_strobe for one cycle. The receiver cannot stall the block.
//   Path: the beat passes the input register, then the result register;
//   o_strobe and the result come together from the result register.
//   Throughput: one beat per cycle while o_busy is low; the single memory read
//   port and the result register each serve one beat per cycle.
//   Reset: synchronous, active low. Afterwards a clearing pass zeroes the
//   storage memory one word per cycle, words 0 to NUM_REGS-1, with o_busy high.
//   Irq and display-enable in each result reflect the state after that beat.
module display_controller_register_block_unit #(
    parameter int unsigned NUM_REGS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  dcrb_pkg::t_in_item  i_item,
    output logic                o_busy,
    output logic                o_strobe,
    output dcrb_pkg::t_out_item o_result
);

    localparam int unsigned AW = $clog2(NUM_REGS);
    localparam logic [dcrb_pkg::IDX_W:0] NUM_REGS_X = (dcrb_pkg::IDX_W + 1)'(NUM_REGS);

    logic                        accept;
    logic                        clearing;
    logic                        r_s1_vld;
    dcrb_pkg::t_in_item          r_s1_item;
    logic                        r_strobe;
    dcrb_pkg::t_out_item         r_result;
    dcrb_pkg::t_out_item         n_result;
    dcrb_pkg::t_ctrl_status      ctrl_st;
    logic [dcrb_pkg::DATA_W-1:0] mem_rd_data;
    logic                        s1_in_range;
    logic                        mem_wr_en;

    assign accept = i_start && !clearing;
    assign o_busy = clearing;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= i_item;
        end
    end

    assign s1_in_range = {1'b0, r_s1_item.word_index} < NUM_REGS_X;

    // Special words
    dcrb_ctrl_regs u_ctrl_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_s1_vld),
        .i_item   (r_s1_item),
        .o_status (ctrl_st)
    );

    // Plain storage: bus-written only by in-range writes that miss the special words
    assign mem_wr_en = r_s1_vld && (r_s1_item.kind == dcrb_pkg::KIND_WRITE) &&
                       s1_in_range && !ctrl_st.hit;

    dcrb_word_mem #(
        .NUM_REGS (NUM_REGS)
    ) u_word_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_idx   (i_item.word_index[AW-1:0]),
        .i_wr_en    (mem_wr_en),
        .i_wr_idx   (r_s1_item.word_index[AW-1:0]),
        .i_wr_data  (r_s1_item.write_data),
        .o_rd_data  (mem_rd_data),
        .o_clearing (clearing)
    );

    // Result assembly
    always_comb begin
        n_result.read_data       = '0;
        n_result.irq_line        = ctrl_st.irq;
        n_result.display_enabled = ctrl_st.disp_en;
        if (r_s1_item.kind == dcrb_pkg::KIND_READ) begin
            if (ctrl_st.hit) begin
                n_result.read_data = ctrl_st.rd_val;
            end else if (s1_in_range) begin
                n_result.read_data = mem_rd_data;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
